### hw/rtl/gcbf_pkg.sv
// ----------------------------------------------------------------------------
// gcbf_pkg
// Shared types, constants and helpers for the Gray-coded bit-flip hill climber.
// ----------------------------------------------------------------------------
package gcbf_pkg;

    // Genome geometry
    localparam int MAX_DIMS  = 16;
    localparam int BITS_EACH = 16;
    localparam int DIM_W     = $clog2(MAX_DIMS);
    localparam int POS_W     = $clog2(BITS_EACH);
    localparam int SQ_W      = 2 * BITS_EACH;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 14;
    localparam int ADIM_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 14;

    // Centring constant M = 2^BITS_EACH - 1 and its square
    localparam logic [BITS_EACH-1:0] CODE_MAX = '1;
    localparam logic [SQ_W-1:0]      SQ_MAX   = CODE_MAX * CODE_MAX;

    // Reset values
    localparam logic [ADIM_W-1:0] RESET_ACTIVE = ADIM_W'(2);
    localparam logic [ADIM_W-1:0] ACTIVE_MAX   = ADIM_W'(MAX_DIMS);
    localparam logic [CNT_W-1:0]  RESET_BUDGET = CNT_W'(10000);
    localparam logic [CNT_W-1:0]  RESET_COUNT  = CNT_W'(1);
    localparam logic [SUM_W-1:0]  RESET_SUM    = SUM_W'(RESET_ACTIVE) * SUM_W'(SQ_MAX);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_BUDGET = 1'b1;

    typedef enum logic [1:0] {
        ST_REJECTED  = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [DIM_W-1:0] dim_index;
        logic [POS_W-1:0] bit_position;
    } t_in;

    typedef struct packed {
        logic [SUM_W-1:0] candidate_sum;
        logic [SUM_W-1:0] best_sum;
        t_status          status;
        logic [CNT_W-1:0] eval_count;
    } t_out;

    // One genome entry: Gray code plus the square of its centred value
    typedef struct packed {
        logic [BITS_EACH-1:0] gray;
        logic [SQ_W-1:0]      sq;
    } t_entry;

    // Gray of all-ones is the top bit alone; its centred value is M
    localparam t_entry ENTRY_RESET = '{gray: BITS_EACH'(1) << (BITS_EACH - 1), sq: SQ_MAX};

    // Gray to binary by a log-depth prefix XOR
    function automatic logic [BITS_EACH-1:0] gray_to_bin(input logic [BITS_EACH-1:0] g);
        logic [BITS_EACH-1:0] b;
        b = g;
        for (int s = 1; s < BITS_EACH; s = s * 2) begin
            b = b ^ (b >> s);
        end
        return b;
    endfunction

endpackage

### hw/rtl/gcbf_genome_mem.sv
// ----------------------------------------------------------------------------
// gcbf_genome_mem
// Genome store: one entry per dimension, one write and one registered read a
// cycle. Entries never written since the last clear read as the reset entry.
// ----------------------------------------------------------------------------
module gcbf_genome_mem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic [gcbf_pkg::DIM_W-1:0] i_rd_addr,
    output gcbf_pkg::t_entry      o_rd_entry,
    input  logic                  i_wr_en,
    input  logic [gcbf_pkg::DIM_W-1:0] i_wr_addr,
    input  gcbf_pkg::t_entry      i_wr_entry
);
    import gcbf_pkg::*;

    t_entry              r_mem [MAX_DIMS];
    logic [MAX_DIMS-1:0] r_valid;
    t_entry              r_rd_data;
    logic                r_rd_hit;

    // Storage array and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Valid bits: drop all on reset or restart, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_hit <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_hit ? r_rd_data : ENTRY_RESET;

endmodule

### hw/rtl/gcbf_flip_eval.sv
// ----------------------------------------------------------------------------
// gcbf_flip_eval
// Apply one bit flip to a Gray code, decode it and square the centred value.
// ----------------------------------------------------------------------------
module gcbf_flip_eval (
    input  logic [gcbf_pkg::BITS_EACH-1:0] i_gray,
    input  logic [gcbf_pkg::POS_W-1:0]     i_pos,
    output logic [gcbf_pkg::BITS_EACH-1:0] o_gray_new,
    output logic [gcbf_pkg::SQ_W-1:0]      o_sq_new
);
    import gcbf_pkg::*;

    logic [BITS_EACH-1:0] bin_new;
    logic [BITS_EACH-1:0] mag;

    // Flip the selected code bit and decode
    assign o_gray_new = i_gray ^ (BITS_EACH'(1) << i_pos);
    assign bin_new    = gray_to_bin(o_gray_new);

    // |2b - M|: upper half gives 2b+1-2^n, lower half gives M-2b (the
    // complement of 2b); both are odd, so the bottom bit is always set
    assign mag = {bin_new[BITS_EACH-2:0] ^ {(BITS_EACH-1){~bin_new[BITS_EACH-1]}}, 1'b1};

    assign o_sq_new = SQ_W'(mag) * SQ_W'(mag);

endmodule

### hw/rtl/gcbf_sum_ctrl.sv
// ----------------------------------------------------------------------------
// gcbf_sum_ctrl
// Running sums, evaluation count and configuration. Decides each proposal
// from the squares delivered by the evaluation stage.
// ----------------------------------------------------------------------------
module gcbf_sum_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [gcbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gcbf_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output logic                            o_restart,
    input  logic                            i_go,
    input  logic [gcbf_pkg::DIM_W-1:0]      i_dim,
    input  logic [gcbf_pkg::SQ_W-1:0]       i_sq_old,
    input  logic [gcbf_pkg::SQ_W-1:0]       i_sq_new,
    output gcbf_pkg::t_out                  o_result,
    output logic                            o_wr_en
);
    import gcbf_pkg::*;

    logic [ADIM_W-1:0] r_active;
    logic [CNT_W-1:0]  r_budget;
    logic [SUM_W-1:0]  r_cur;
    logic [SUM_W-1:0]  r_best;
    logic [CNT_W-1:0]  r_count;

    logic [ADIM_W-1:0] cfg_active;
    logic [SUM_W-1:0]  cfg_sum;
    logic              exhausted;
    logic              in_range;
    logic              evaluate;
    logic [SUM_W-1:0]  cand;
    logic              improves;
    logic [SUM_W-1:0]  n_best;
    logic [CNT_W-1:0]  n_count;

    // Clamp the dimension count and form the restart sum
    always_comb begin
        cfg_active = i_cfg_data[ADIM_W-1:0];
        if (cfg_active == '0) begin
            cfg_active = ADIM_W'(1);
        end else if (cfg_active > ACTIVE_MAX) begin
            cfg_active = ACTIVE_MAX;
        end
        cfg_sum = SUM_W'(cfg_active) * SUM_W'(SQ_MAX);
    end

    assign o_restart = i_cfg_valid && (i_cfg_index == CFG_ACTIVE_DIMS);

    // Decide the proposal
    assign exhausted = r_count >= r_budget;
    assign in_range  = ADIM_W'(i_dim) < r_active;
    assign evaluate  = !exhausted && in_range;
    assign cand      = r_cur - SUM_W'(i_sq_old) + SUM_W'(i_sq_new);
    assign improves  = cand < r_cur;
    assign n_best    = (cand < r_best) ? cand : r_best;
    assign n_count   = r_count + CNT_W'(1);
    assign o_wr_en   = i_go && evaluate && improves;

    always_comb begin
        o_result.candidate_sum = r_cur;
        o_result.best_sum      = r_best;
        o_result.eval_count    = r_count;
        if (exhausted) begin
            o_result.status = ST_EXHAUSTED;
        end else if (!in_range) begin
            o_result.status = ST_RANGE;
        end else begin
            o_result.candidate_sum = cand;
            o_result.best_sum      = n_best;
            o_result.eval_count    = n_count;
            o_result.status        = improves ? ST_ACCEPTED : ST_REJECTED;
        end
    end

    // Hold state; restart on a dimension-count write, advance on each evaluated proposal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= RESET_ACTIVE;
            r_budget <= RESET_BUDGET;
            r_cur    <= RESET_SUM;
            r_best   <= RESET_SUM;
            r_count  <= RESET_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_DIMS: begin
                    r_active <= cfg_active;
                    r_cur    <= cfg_sum;
                    r_best   <= cfg_sum;
                    r_count  <= RESET_COUNT;
                end
                CFG_EVAL_BUDGET: begin
                    r_budget <= i_cfg_data[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_go && evaluate) begin
            r_count <= n_count;
            r_best  <= n_best;
            if (improves) begin
                r_cur <= cand;
            end
        end
    end

endmodule

### hw/rtl/gray_coded_bit_flip_hill_climb_unit.sv
// ----------------------------------------------------------------------------
// gray_coded_bit_flip_hill_climb_unit
// Bit-flip hill climber over a Gray-coded genome with a sphere objective.
// ----------------------------------------------------------------------------
// Usage:
//   Proposals arrive on the in channel (dim_index, bit_position), one result
//   leaves on the out channel per proposal, in order. The config channel
//   writes active_dims (index 0, restarts the search) or eval_budget (index 1)
//   and is always ready; write it only while no proposal is in flight.
// Path: the genome read is issued at the edge on which a proposal transfers,
//   the flip and square go into the second stage and the sum update into the
//   output register, from which the result is presented.
// Throughput: one proposal per cycle while results are taken, set by the
//   single genome memory port and the sum loop. Two consecutive proposals on
//   the same dimension are held apart: the second waits in the read stage until
//   the first leaves, since it must see the written-back genome entry of the first.
// Reset: sums take active_dims * M^2, the evaluation count takes one and every
//   genome entry reads as the Gray code of all-ones through per-entry valid
//   bits; no clearing pass, the block accepts proposals at once.
// Stall: when the receiver holds off, the result waits in the output register
//   and the pipeline keeps taking proposals until all three stages are full.
// ----------------------------------------------------------------------------
module gray_coded_bit_flip_hill_climb_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  gcbf_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gcbf_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gcbf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gcbf_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import gcbf_pkg::*;

    // Read stage
    logic              r_s1_valid;
    logic [DIM_W-1:0]  r_s1_dim;
    logic [POS_W-1:0]  r_s1_pos;
    // Square stage
    logic              r_s2_valid;
    logic [DIM_W-1:0]  r_s2_dim;
    logic [BITS_EACH-1:0] r_s2_gray_new;
    logic [SQ_W-1:0]   r_s2_sq_old;
    logic [SQ_W-1:0]   r_s2_sq_new;
    // Output register
    logic              r_out_valid;
    t_out              r_out_data;
    // Last write-back, for forwarding into the read stage
    logic              r_fw_valid;
    logic [DIM_W-1:0]  r_fw_dim;
    t_entry            r_fw_entry;

    logic              out_free;
    logic              s2_adv;
    logic              s2_free;
    logic              hazard;
    logic              s1_adv;
    logic              in_xfer;
    logic [DIM_W-1:0]  rd_addr;
    t_entry            rd_entry;
    t_entry            s1_entry;
    logic [BITS_EACH-1:0] s1_gray_new;
    logic [SQ_W-1:0]   s1_sq_new;
    logic              restart;
    t_out              result;
    logic              wr_en;
    t_entry            wr_entry;

    // Pipeline flow control
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_adv     = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || s2_adv;
    assign hazard     = r_s2_valid && (r_s2_dim == r_s1_dim);
    assign s1_adv     = r_s1_valid && s2_free && !hazard;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Re-read the held entry while the read stage waits
    assign rd_addr = (r_s1_valid && !s1_adv) ? r_s1_dim : i_in_data.dim_index;

    gcbf_genome_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (restart),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_s2_dim),
        .i_wr_entry (wr_entry)
    );

    // Forward the write that landed on the same edge as the read
    assign s1_entry = (r_fw_valid && (r_fw_dim == r_s1_dim)) ? r_fw_entry : rd_entry;

    gcbf_flip_eval u_eval (
        .i_gray     (s1_entry.gray),
        .i_pos      (r_s1_pos),
        .o_gray_new (s1_gray_new),
        .o_sq_new   (s1_sq_new)
    );

    gcbf_sum_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_restart   (restart),
        .i_go        (s2_adv),
        .i_dim       (r_s2_dim),
        .i_sq_old    (r_s2_sq_old),
        .i_sq_new    (r_s2_sq_new),
        .o_result    (result),
        .o_wr_en     (wr_en)
    );

    assign wr_entry = '{gray: r_s2_gray_new, sq: r_s2_sq_new};

    // Stage valids and forwarding record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fw_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_fw_valid <= wr_en && !restart;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_dim <= i_in_data.dim_index;
            r_s1_pos <= i_in_data.bit_position;
        end
        if (s1_adv) begin
            r_s2_dim      <= r_s1_dim;
            r_s2_gray_new <= s1_gray_new;
            r_s2_sq_old   <= s1_entry.sq;
            r_s2_sq_new   <= s1_sq_new;
        end
        if (s2_adv) begin
            r_out_data <= result;
        end
        if (wr_en) begin
            r_fw_dim   <= r_s2_dim;
            r_fw_entry <= wr_entry;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hw/rtl/gcbf_checker.sv
// ----------------------------------------------------------------------------
// gcbf_checker
// Port-level checks on the hill climber's result stream.
// ----------------------------------------------------------------------------
module gcbf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input gcbf_pkg::t_out o_out_data
);
    import gcbf_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // The best sum never exceeds the reported candidate
    a_best_le_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.best_sum <= o_out_data.candidate_sum)
        else $error("best sum above candidate");

    // An accepted flip is a new best
    a_accept_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_ACCEPTED)
            |-> o_out_data.best_sum == o_out_data.candidate_sum)
        else $error("accepted flip is not the best");

    // The initial evaluation is always counted
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.eval_count != '0)
        else $error("evaluation count is zero");

endmodule

bind gray_coded_bit_flip_hill_climb_unit gcbf_checker u_gcbf_checker (.*);

### dv/gray_coded_bit_flip_hill_climb_unit_tb.sv
// ----------------------------------------------------------------------------
// gray_coded_bit_flip_hill_climb_unit_tb
// Self-checking bench for the Gray-coded bit-flip hill climber.
// A scoreboard class tracks the genome, the running and best sums and the
// evaluation count, and predicts one outcome per proposal. A short directed
// run covers clamping, exhaustion and out-of-range dimensions. Random phases
// then reconfigure the block and vary the pacing on both handshakes.
// ----------------------------------------------------------------------------
module gray_coded_bit_flip_hill_climb_unit_tb;
    import gcbf_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 105;

    // Tracks the climb and holds the outcomes still owed by the block
    class climb_scoreboard;
        logic [BITS_EACH-1:0] genome [MAX_DIMS];
        logic [ADIM_W-1:0]    active_dims;
        logic [CNT_W-1:0]     budget;
        logic [CNT_W-1:0]     evals;
        logic [63:0]          cur_sum;
        logic [63:0]          best_sum;
        t_out                 expected_outcomes [$];
        int                   errors;
        int                   writes;
        int                   tally [4];

        function new();
            active_dims = RESET_ACTIVE;
            budget      = RESET_BUDGET;
            errors      = 0;
            writes      = 0;
            foreach (tally[s]) tally[s] = 0;
            restart_search();
        endfunction

        // Every entry returns to the Gray code of all-ones
        function void restart_search();
            foreach (genome[i]) genome[i] = BITS_EACH'(1) << (BITS_EACH - 1);
            cur_sum  = 64'(active_dims) * 64'(CODE_MAX) * 64'(CODE_MAX);
            best_sum = cur_sum;
            evals    = 1;
        endfunction

        function logic [BITS_EACH-1:0] gray_decode(logic [BITS_EACH-1:0] g);
            logic [BITS_EACH-1:0] b;
            b[BITS_EACH-1] = g[BITS_EACH-1];
            for (int i = BITS_EACH - 2; i >= 0; i--) b[i] = b[i+1] ^ g[i];
            return b;
        endfunction

        // Square of 2b - M, taken through its magnitude
        function logic [63:0] centred_square(logic [BITS_EACH-1:0] b);
            logic [BITS_EACH:0] twice;
            logic [63:0]        mag;
            twice = {b, 1'b0};
            mag = (twice >= {1'b0, CODE_MAX}) ? 64'(twice) - 64'(CODE_MAX)
                                              : 64'(CODE_MAX) - 64'(twice);
            return mag * mag;
        endfunction

        function int outstanding();
            return expected_outcomes.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            logic [ADIM_W-1:0] v;
            writes++;
            if (idx == CFG_ACTIVE_DIMS) begin
                // Keep the low five bits, clamp, then restart the search
                v = data[ADIM_W-1:0];
                if (v < 1) v = 1;
                if (v > ACTIVE_MAX) v = ACTIVE_MAX;
                active_dims = v;
                restart_search();
            end else begin
                budget = data[CNT_W-1:0];
            end
        endfunction

        // Apply one proposal and queue the outcome it must produce
        function void note_proposal(t_in p);
            logic [BITS_EACH-1:0] g_old;
            logic [BITS_EACH-1:0] g_new;
            logic [63:0]          cand;
            t_status              st;
            t_out                 want;
            cand = cur_sum;
            if (evals >= budget) begin
                st = ST_EXHAUSTED;
            end else if ({1'b0, p.dim_index} >= active_dims) begin
                st = ST_RANGE;
            end else begin
                g_old = genome[p.dim_index];
                g_new = g_old ^ (BITS_EACH'(1) << p.bit_position);
                cand  = cur_sum - centred_square(gray_decode(g_old))
                                + centred_square(gray_decode(g_new));
                evals = evals + 1'b1;
                if (cand < best_sum) best_sum = cand;
                // Keep the flip only on a strict drop
                if (cand < cur_sum) begin
                    genome[p.dim_index] = g_new;
                    cur_sum = cand;
                    st = ST_ACCEPTED;
                end else begin
                    st = ST_REJECTED;
                end
            end
            tally[st]++;
            want.candidate_sum = cand[SUM_W-1:0];
            want.best_sum      = best_sum[SUM_W-1:0];
            want.status        = st;
            want.eval_count    = evals;
            expected_outcomes.push_back(want);
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 30)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_outcome(t_out got);
            t_out want;
            if (expected_outcomes.size() == 0) begin
                flag("unexpected result, candidate_sum", 0, got.candidate_sum);
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.candidate_sum !== want.candidate_sum)
                flag("candidate_sum", want.candidate_sum, got.candidate_sum);
            if (got.best_sum !== want.best_sum)
                flag("best_sum", want.best_sum, got.best_sum);
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.eval_count !== want.eval_count)
                flag("eval_count", want.eval_count, got.eval_count);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 o_in_ready;
    t_in                  in_data;
    logic                 o_out_valid;
    logic                 out_ready;
    t_out                 o_out_data;
    logic                 cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    climb_scoreboard sb;
    int              idle_cycles;
    int              src_idle_pct;
    int              sink_stall_pct;

    gray_coded_bit_flip_hill_climb_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Note every transfer on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) sb.check_outcome(o_out_data);
            if (in_valid && o_in_ready) sb.note_proposal(in_data);
            if (cfg_valid && o_cfg_ready) sb.write_register(cfg_index, cfg_data);
        end
    end

    // Drop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic propose(input int d, input int p);
        t_in item;
        item.dim_index    = d[DIM_W-1:0];
        item.bit_position = p[POS_W-1:0];
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold off proposals until every outcome is back and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int dims_raw;
        int budget_raw;
        int d;
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ACTIVE_DIMS;
        cfg_data       = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        idle_cycles    = 0;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: a top-bit flip that leaves the square alone, steps
        // towards the centre, and dimensions outside the active range
        propose(0, 15);
        propose(0, 0);
        propose(1, 14);
        propose(1, 13);
        propose(2, 3);
        propose(15, 15);
        propose(1, 14);
        propose(0, 8);
        propose(1, 1);

        // Full width, largest budget
        settle();
        cfg_write(CFG_ACTIVE_DIMS, CFG_DAT_W'(16));
        cfg_write(CFG_EVAL_BUDGET, CFG_DAT_W'(16383));
        propose(15, 15);
        propose(15, 0);
        propose(7, 10);
        propose(15, 14);
        propose(0, 5);

        // Low bits zero clamp to one dimension; a tiny budget runs out,
        // and exhaustion wins over an out-of-range dimension
        settle();
        cfg_write(CFG_ACTIVE_DIMS, CFG_DAT_W'(14'h2AA0));
        cfg_write(CFG_EVAL_BUDGET, CFG_DAT_W'(3));
        propose(0, 14);
        propose(1, 0);
        propose(0, 12);
        propose(0, 3);
        propose(9, 9);

        // Zero budget ignores everything
        settle();
        cfg_write(CFG_EVAL_BUDGET, CFG_DAT_W'(0));
        propose(0, 0);

        // Seventeen in the low bits clamps to the maximum
        settle();
        cfg_write(CFG_ACTIVE_DIMS, CFG_DAT_W'(14'h3FF1));
        cfg_write(CFG_EVAL_BUDGET, CFG_DAT_W'(5));
        propose(12, 15);
        propose(3, 2);

        // Random phases: new settings and pacing each time
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 67;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 67;
                end
                default: begin
                    src_idle_pct = 12;
                    sink_stall_pct = 12;
                end
            endcase
            case (ph % 6)
                0: dims_raw = 1;
                1: dims_raw = 16;
                2: dims_raw = $urandom_range(1, 16);
                3: dims_raw = $urandom_range(0, 16383);
                4: dims_raw = $urandom_range(2, 8);
                default: dims_raw = $urandom_range(9, 16);
            endcase
            if (ph % 5 == 3)
                budget_raw = $urandom_range(2, 40);
            else if (ph == 6)
                budget_raw = 16383;
            else
                budget_raw = $urandom_range(300, 16382);
            cfg_write(CFG_ACTIVE_DIMS, CFG_DAT_W'(dims_raw));
            cfg_write(CFG_EVAL_BUDGET, CFG_DAT_W'(budget_raw));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Raise a spent budget halfway and carry on from the same genome
                if (k == PHASE_ITEMS / 2 && ph % 5 == 3) begin
                    settle();
                    cfg_write(CFG_EVAL_BUDGET, CFG_DAT_W'($urandom_range(2000, 16383)));
                end
                if ($urandom_range(0, 99) < 88)
                    d = $urandom_range(0, int'(sb.active_dims) - 1);
                else
                    d = $urandom_range(0, 15);
                propose(d, $urandom_range(0, 15));
            end
        end

        settle();
        $display("run covered %0d proposals: %0d kept, %0d turned down, %0d over budget, %0d off range",
                 sb.tally[ST_ACCEPTED] + sb.tally[ST_REJECTED] + sb.tally[ST_EXHAUSTED]
                 + sb.tally[ST_RANGE], sb.tally[ST_ACCEPTED], sb.tally[ST_REJECTED],
                 sb.tally[ST_EXHAUSTED], sb.tally[ST_RANGE]);
        $display("%0d register writes across one to sixteen dimensions and four pacing modes",
                 sb.writes);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
hw/rtl/gcbf_pkg.sv
hw/rtl/gcbf_genome_mem.sv
hw/rtl/gcbf_flip_eval.sv
hw/rtl/gcbf_sum_ctrl.sv
hw/rtl/gray_coded_bit_flip_hill_climb_unit.sv
hw/rtl/gcbf_checker.sv
dv/gray_coded_bit_flip_hill_climb_unit_tb.sv
